// ----- rtl/wrr_pkg.sv -----
// ----------------------------------------------------------------------------
// Weighted round-robin picker package
// Shared widths, codes and the controller state type.
// ----------------------------------------------------------------------------
package wrr_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int WEIGHT_W    = 16;
    localparam int CURSOR_W    = 32;
    // Largest possible total is MAX_ENTRIES * (2^WEIGHT_W - 1).
    localparam int SUM_W       = WEIGHT_W + IDX_W;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_PICK  = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/wrr_weight_mem.sv -----
// ----------------------------------------------------------------------------
// Weight table memory
// Synchronous single-write, single-read table; read data is registered and appears in the cycle after rd_en.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module wrr_weight_mem
    import wrr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  logic [WEIGHT_W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output logic [WEIGHT_W-1:0] rd_data
);

    logic [WEIGHT_W-1:0]    table_reg [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [WEIGHT_W-1:0]    rd_data_reg;
    logic                   rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

// ----- rtl/wrr_mod_unit.sv -----
// ----------------------------------------------------------------------------
// Cursor modulo unit
// Restoring remainder computation, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module wrr_mod_unit
    import wrr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CURSOR_W-1:0] dividend,
    input  logic [SUM_W-1:0]    divisor,
    output logic                done,
    output logic [SUM_W-1:0]    remainder
);

    localparam int STEP_W = $clog2(CURSOR_W);

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic [STEP_W-1:0]   step_reg,  step_next;
    logic [CURSOR_W-1:0] dvd_reg,   dvd_next;
    logic [SUM_W-1:0]    dsr_reg,   dsr_next;
    logic [SUM_W-1:0]    rem_reg,   rem_next;
    logic [SUM_W:0]      trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[CURSOR_W-1]};

        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below twice the divisor, so one
            // compare and subtract settles each bit.
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = SUM_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[SUM_W-1:0];
            end
            dvd_next  = {dvd_reg[CURSOR_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(CURSOR_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/weighted_round_robin_picker.sv -----
// A write, or a pick with no entries in use, goes straight to ST_DONE; a pick
// over N entries makes two passes over the weight memory, a summing pass and a
// scan that stops at the chosen entry, with a bit-serial cursor modulo between.
// One item is in work at a time; the next is taken once the result is loaded
// into the output register, accepted or not.
// Reset clears the weight table (per-entry valid bits), the cursor and entry_count.
// ----------------------------------------------------------------------------
// Weighted round-robin picker
// Stores per-entry weights and picks entries in proportion to their weights
// using a wrapping cursor taken modulo the total weight.
// ----------------------------------------------------------------------------
module weighted_round_robin_picker
    import wrr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CNT_W-1:0]    cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                action,
    input  logic [IDX_W-1:0]    entry_index,
    input  logic [WEIGHT_W-1:0] weight_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                status,
    output logic [IDX_W-1:0]    chosen_index
);

    state_t              state_reg,      state_next;
    logic [CNT_W-1:0]    entry_count_reg;
    logic [CURSOR_W-1:0] cursor_reg,     cursor_next;
    logic [CNT_W-1:0]    n_reg,          n_next;
    logic [CNT_W-1:0]    iss_reg,        iss_next;
    logic                rd_pend_reg,    rd_pend_next;
    logic [IDX_W-1:0]    rd_idx_reg,     rd_idx_next;
    logic [SUM_W-1:0]    total_reg,      total_next;
    logic [SUM_W-1:0]    run_reg,        run_next;
    logic [SUM_W-1:0]    pos_reg,        pos_next;
    logic                res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_index_reg,  res_index_next;
    logic                out_valid_reg,  out_valid_next;
    logic                out_status_reg, out_status_next;
    logic [IDX_W-1:0]    out_index_reg,  out_index_next;

    logic                mem_wr;
    logic                mem_rd;
    logic [WEIGHT_W-1:0] mem_rd_data;
    logic                div_start;
    logic                div_done;
    logic [SUM_W-1:0]    div_rem;
    logic [CNT_W-1:0]    n_sat;
    logic [SUM_W-1:0]    eff_weight;
    logic [SUM_W-1:0]    run_sum;
    logic                hit;

    wrr_weight_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr),
        .wr_addr (entry_index),
        .wr_data (weight_value),
        .rd_en   (mem_rd),
        .rd_addr (iss_reg[IDX_W-1:0]),
        .rd_data (mem_rd_data)
    );

    wrr_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (cursor_reg),
        .divisor   (total_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign n_sat = (entry_count_reg > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                          : entry_count_reg;

    // A zero weight counts as one.
    assign eff_weight = (mem_rd_data == '0) ? SUM_W'(1)
                                            : {{(SUM_W-WEIGHT_W){1'b0}}, mem_rd_data};
    assign run_sum    = run_reg + eff_weight;
    assign hit        = rd_pend_reg && (pos_reg < run_sum);

    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        n_next          = n_reg;
        iss_next        = iss_reg;
        rd_pend_next    = rd_pend_reg;
        rd_idx_next     = rd_idx_reg;
        total_next      = total_reg;
        run_next        = run_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        mem_wr          = 1'b0;
        mem_rd          = 1'b0;
        div_start       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == ACT_WRITE)
                    begin
                        mem_wr          = 1'b1;
                        res_status_next = STATUS_OK;
                        res_index_next  = entry_index;
                        state_next      = ST_DONE;
                    end
                    else if (n_sat == '0)
                    begin
                        res_status_next = STATUS_NOT_FOUND;
                        res_index_next  = '0;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        n_next       = n_sat;
                        iss_next     = '0;
                        rd_pend_next = 1'b0;
                        total_next   = '0;
                        state_next   = ST_SUM;
                    end
                end
            end

            ST_SUM:
            begin
                rd_pend_next = 1'b0;
                if (iss_reg < n_reg)
                begin
                    mem_rd       = 1'b1;
                    iss_next     = iss_reg + 1'b1;
                    rd_pend_next = 1'b1;
                end
                if (rd_pend_reg)
                begin
                    total_next = total_reg + eff_weight;
                end
                if ((iss_reg == n_reg) && !rd_pend_reg)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    pos_next     = div_rem;
                    cursor_next  = cursor_reg + 1'b1;
                    iss_next     = '0;
                    rd_pend_next = 1'b0;
                    run_next     = '0;
                    state_next   = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                rd_pend_next = 1'b0;
                if (rd_pend_reg)
                begin
                    run_next = run_sum;
                end
                if (hit)
                begin
                    res_status_next = STATUS_OK;
                    res_index_next  = rd_idx_reg;
                    state_next      = ST_DONE;
                end
                else if (iss_reg < n_reg)
                begin
                    mem_rd       = 1'b1;
                    rd_idx_next  = iss_reg[IDX_W-1:0];
                    iss_next     = iss_reg + 1'b1;
                    rd_pend_next = 1'b1;
                end
            end

            ST_DONE:
            begin
                // Load the output register once it is free or being drained.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = res_index_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            cursor_reg      <= '0;
            n_reg           <= '0;
            iss_reg         <= '0;
            rd_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            n_reg         <= n_next;
            iss_reg       <= iss_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                entry_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        total_reg      <= total_next;
        run_reg        <= run_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign chosen_index = out_index_reg;

`ifndef NO_ASSERTIONS
    a_cursor_moves_on_pick: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_reg != $past(cursor_reg)) |-> $past(state_reg == ST_DIV && div_done))
        else $error("cursor changed outside a completed pick");

    a_rem_below_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_done) |-> (div_rem < total_reg))
        else $error("modulo result not below total weight");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && rd_pend_reg) |-> (run_reg < total_reg))
        else $error("scan ran past the total weight without a hit");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr && mem_rd))
        else $error("weight memory read and write in the same cycle");
`endif

endmodule
